/* hw/rtl/tlq_pkg.sv */
// Shared types, codes and constants of the three-class lottery queue.
package tlq_pkg;

	localparam int QUEUE_DEPTH_DEF = 64;
	localparam int TAG_WIDTH_DEF   = 16;
	localparam int DRAW_LIMIT_DEF  = 256;

	localparam logic [34:0] LCG_MUL      = 35'h5DEECE66D;
	localparam logic [63:0] LCG_ADD      = 64'hB;
	localparam logic [15:0] LCG_SEED_LOW = 16'h330E;
	localparam logic [47:0] LCG_RESET    = 48'h330E;

	localparam logic [31:0] HIGH_ADDR_RESET = 32'd2149590592;
	localparam logic [31:0] MID_ADDR_RESET  = 32'd2149590593;
	localparam logic [15:0] TK_HIGH_RESET   = 16'd80;
	localparam logic [15:0] TK_MID_RESET    = 16'd60;
	localparam logic [15:0] TK_TOTAL_RESET  = 16'd150;

	localparam logic [2:0] REG_HIGH_ADDR = 3'd0;
	localparam logic [2:0] REG_MID_ADDR  = 3'd1;
	localparam logic [2:0] REG_TK_HIGH   = 3'd2;
	localparam logic [2:0] REG_TK_MID    = 3'd3;
	localparam logic [2:0] REG_TK_TOTAL  = 3'd4;
	localparam logic [2:0] REG_SEED      = 3'd5;

	localparam logic OP_ENQ = 1'b0;
	localparam logic OP_DEQ = 1'b1;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_LIMIT = 2'd3;

	localparam logic [1:0] CLS_HIGH = 2'd0;
	localparam logic [1:0] CLS_MID  = 2'd1;
	localparam logic [1:0] CLS_LOW  = 2'd2;

	typedef struct packed {
		logic        opcode;
		logic [15:0] item_tag;
		logic [31:0] client_addr;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] out_tag;
		logic [1:0]  out_class;
		logic [7:0]  total_count;
	} rsp_t;

	typedef struct packed {
		logic start;
		logic lcg_mode;
	} mac_ctl_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ENQ,
		S_DEQ,
		S_LCG,
		S_CMP,
		S_POP,
		S_RESULT
	} state_t;

endpackage

/* hw/rtl/three_class_lottery_queue.sv */
// Top level of the three-class lottery queue: sequencer, configuration and result register.
//
// Request channel (req_valid/req_stall/req): opcode enqueue puts item_tag into the
// high, middle or low FIFO by client_addr; opcode dequeue draws a class by lottery.
// Each request beat yields exactly one response beat (rsp_valid/rsp_stall/rsp).
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready and
// index 5 reseeds the generator; the user must write it only while the block is idle,
// which the block itself does not enforce. An enqueue or an empty dequeue goes straight
// on to the result; a dequeue draws until a draw wins (that class is then popped) or
// DRAW_LIMIT draws miss. Each draw is two passes through the one shared multiply-
// accumulate unit (generator step, then the ticket compare product). One request is
// in flight at a time; req_stall is high from the accepting edge until the response
// is loaded, so the next request beat comes only after that.
// A finished response is held in the output register while rsp_stall is high and
// the next request can be taken meanwhile; its own response waits until that beat
// is taken.
// Reset clears FIFO pointers and counts, loads the register reset values and the
// generator state 0x330E. FIFO storage is not cleared.
module three_class_lottery_queue import tlq_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int TAG_WIDTH   = TAG_WIDTH_DEF,
	parameter int DRAW_LIMIT  = DRAW_LIMIT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  req_t        req,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output rsp_t        rsp,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int SW = (TAG_WIDTH < 16) ? TAG_WIDTH : 16;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int DW = $clog2(DRAW_LIMIT + 1);

	state_t state_q, state_d;

	req_t        req_q;
	logic [31:0] high_addr_q;
	logic [31:0] mid_addr_q;
	logic [15:0] tk_high_q;
	logic [15:0] tk_mid_q;
	logic [15:0] tk_total_q;
	logic [47:0] lcg_q;
	logic [DW-1:0] draws_q;
	logic [1:0]  status_q;
	logic [1:0]  cls_q;
	logic [15:0] tag_q;
	rsp_t        rsp_q;
	logic        rsp_valid_q;

	logic [2:0]    push;
	logic [2:0]    pop;
	logic [SW-1:0] rdata [3];
	logic [CW-1:0] cnt [3];
	logic [CW+1:0] total_sum;

	mac_ctl_t    mac_ctl;
	logic [63:0] mac_acc;
	logic        mac_done;

	logic        req_beat;
	logic        rsp_load;
	logic [1:0]  enq_cls;
	logic        enq_full;
	logic [1:0]  draw_cls;
	logic        draw_hit;
	logic        draw_last;
	logic        hi_hold;
	logic        mid_hold;
	logic [16:0] both;

	for (genvar c = 0; c < 3; c++) begin : g_fifo
		tlq_fifo #(
			.DEPTH(QUEUE_DEPTH),
			.WIDTH(SW)
		) u_fifo (
			.clk   (clk),
			.arst_n(arst_n),
			.push  (push[c]),
			.pop   (pop[c]),
			.wdata (req_q.item_tag[SW-1:0]),
			.rdata (rdata[c]),
			.count (cnt[c])
		);
	end

	tlq_mac u_mac (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (mac_ctl),
		.x     (lcg_q),
		.total (tk_total_q),
		.acc   (mac_acc),
		.done  (mac_done)
	);

	assign req_stall = (state_q != S_IDLE);
	assign req_beat  = req_valid && !req_stall;
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign rsp_load  = (state_q == S_RESULT) && (!rsp_valid_q || !rsp_stall);

	always_comb begin
		total_sum = (CW+2)'(cnt[0]) + (CW+2)'(cnt[1]) + (CW+2)'(cnt[2]);
		if (req_q.client_addr == high_addr_q) begin
			enq_cls = CLS_HIGH;
		end else if (req_q.client_addr == mid_addr_q) begin
			enq_cls = CLS_MID;
		end else begin
			enq_cls = CLS_LOW;
		end
		enq_full = (cnt[enq_cls] == CW'(QUEUE_DEPTH));
		both     = 17'(tk_high_q) + 17'(tk_mid_q);
		hi_hold  = (tk_high_q >= tk_total_q) || (mac_acc <= {tk_high_q, 48'd0});
		mid_hold = (both >= 17'(tk_total_q)) || (mac_acc <= {both[15:0], 48'd0});
		if (hi_hold) begin
			draw_cls = CLS_HIGH;
		end else if (mid_hold) begin
			draw_cls = CLS_MID;
		end else begin
			draw_cls = CLS_LOW;
		end
		draw_hit  = (cnt[draw_cls] != '0);
		draw_last = (draws_q == DW'(DRAW_LIMIT - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		push    = '0;
		pop     = '0;
		mac_ctl = '0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_d = (req.opcode == OP_ENQ) ? S_ENQ : S_DEQ;
				end
			end
			S_ENQ: begin
				if (!enq_full) begin
					push[enq_cls] = 1'b1;
				end
				state_d = S_RESULT;
			end
			S_DEQ: begin
				if (total_sum == '0) begin
					state_d = S_RESULT;
				end else begin
					mac_ctl.start    = 1'b1;
					mac_ctl.lcg_mode = 1'b1;
					state_d          = S_LCG;
				end
			end
			S_LCG: begin
				if (mac_done) begin
					mac_ctl.start = 1'b1;
					state_d       = S_CMP;
				end
			end
			S_CMP: begin
				if (mac_done) begin
					if (draw_hit) begin
						pop[draw_cls] = 1'b1;
						state_d       = S_POP;
					end else if (draw_last) begin
						state_d = S_RESULT;
					end else begin
						mac_ctl.start    = 1'b1;
						mac_ctl.lcg_mode = 1'b1;
						state_d          = S_LCG;
					end
				end
			end
			S_POP: begin
				state_d = S_RESULT;
			end
			S_RESULT: begin
				if (!rsp_valid_q || !rsp_stall) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_addr_q <= HIGH_ADDR_RESET;
			mid_addr_q  <= MID_ADDR_RESET;
			tk_high_q   <= TK_HIGH_RESET;
			tk_mid_q    <= TK_MID_RESET;
			tk_total_q  <= TK_TOTAL_RESET;
			lcg_q       <= LCG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_HIGH_ADDR: high_addr_q <= cfg_data;
				REG_MID_ADDR:  mid_addr_q  <= cfg_data;
				REG_TK_HIGH:   tk_high_q   <= cfg_data[15:0];
				REG_TK_MID:    tk_mid_q    <= cfg_data[15:0];
				REG_TK_TOTAL:  tk_total_q  <= cfg_data[15:0];
				REG_SEED:      lcg_q       <= {cfg_data, LCG_SEED_LOW};
				default: ;
			endcase
		end else if (state_q == S_LCG && mac_done) begin
			lcg_q <= mac_acc[47:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			draws_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DEQ) begin
				draws_q <= '0;
			end else if (state_q == S_CMP && mac_done && !draw_hit) begin
				draws_q <= draws_q + 1'b1;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_beat) begin
			req_q <= req;
		end
		case (state_q)
			S_ENQ: begin
				cls_q    <= enq_cls;
				status_q <= enq_full ? ST_FULL : ST_DONE;
				tag_q    <= '0;
			end
			S_DEQ: begin
				cls_q    <= CLS_HIGH;
				status_q <= ST_EMPTY;
				tag_q    <= '0;
			end
			S_CMP: begin
				if (mac_done) begin
					cls_q    <= draw_cls;
					status_q <= draw_hit ? ST_DONE : ST_LIMIT;
				end
			end
			S_POP: begin
				tag_q <= 16'(rdata[cls_q]);
			end
			default: ;
		endcase
		if (rsp_load) begin
			rsp_q.status      <= status_q;
			rsp_q.out_tag     <= tag_q;
			rsp_q.out_class   <= cls_q;
			rsp_q.total_count <= 8'(total_sum);
		end
	end

	a_pop_only_on_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(pop != '0) |-> (state_q == S_CMP) && mac_done && draw_hit)
		else $error("fifo pop outside a winning draw");
	a_one_fifo_op: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({push, pop}))
		else $error("more than one fifo touched");
	a_result_follows_load: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_load |=> rsp_valid_q && state_q == S_IDLE)
		else $error("response not presented after load");

endmodule

/* hw/rtl/tlq_fifo.sv */
// One class FIFO: circular buffer memory with registered read, pointers and fill count.
module tlq_fifo import tlq_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF,
	parameter int WIDTH = TAG_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  logic                         pop,
	input  logic [WIDTH-1:0]             wdata,
	output logic [WIDTH-1:0]             rdata,
	output logic [$clog2(DEPTH+1)-1:0]   count
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;
	logic [PW-1:0]    head_q;
	logic [PW-1:0]    tail_q;
	logic [CW-1:0]    count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[tail_q] <= wdata;
		end
		if (pop) begin
			rdata_q <= mem[head_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				tail_q  <= (tail_q == PW'(DEPTH - 1)) ? '0 : tail_q + 1'b1;
				count_q <= count_q + 1'b1;
			end else if (pop) begin
				head_q  <= (head_q == PW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign rdata = rdata_q;
	assign count = count_q;

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> count_q < CW'(DEPTH))
		else $error("push into full fifo");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("pop from empty fifo");
	a_no_both: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && pop))
		else $error("push and pop in one cycle");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> count_q == $past(count_q) + 1'b1)
		else $error("fill count did not advance");

endmodule

/* hw/rtl/tlq_mac.sv */
// Shared 16x35 multiply-accumulate unit: one 48-bit operand times a constant or the ticket total.
module tlq_mac import tlq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  mac_ctl_t    ctl,
	input  logic [47:0] x,
	input  logic [15:0] total,
	output logic [63:0] acc,
	output logic        done
);

	logic [1:0]  step_q;
	logic        busy_q;
	logic        done_q;
	logic        mode_q;
	logic [50:0] mul_q;
	logic [63:0] acc_q;
	logic [15:0] chunk;
	logic [34:0] mult_b;
	logic [63:0] addend;

	always_comb begin
		case (step_q)
			2'd0:    chunk = x[15:0];
			2'd1:    chunk = x[31:16];
			default: chunk = x[47:32];
		endcase
		mult_b = mode_q ? LCG_MUL : 35'(total);
		case (step_q)
			2'd1:    addend = 64'(mul_q);
			2'd2:    addend = 64'(mul_q) << 16;
			2'd3:    addend = 64'(mul_q) << 32;
			default: addend = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
			mode_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
				mode_q <= ctl.lcg_mode;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == 2'd3) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			acc_q <= ctl.lcg_mode ? LCG_ADD : '0;
		end else if (busy_q) begin
			if (step_q != 2'd3) begin
				mul_q <= 51'(chunk * mult_b);
			end
			acc_q <= acc_q + addend;
		end
	end

	assign acc  = acc_q;
	assign done = done_q;

endmodule

/* tb/three_class_lottery_queue_test.sv */
// Self-checking testbench of the three-class lottery queue: queued stimulus, predictor, checker.
module three_class_lottery_queue_test;
	import tlq_pkg::*;

	localparam int DEPTH       = QUEUE_DEPTH_DEF;
	localparam int DRAWS       = DRAW_LIMIT_DEF;
	localparam int QUIET_LIMIT = 20000;
	localparam int HOLD_CYCLES = 400;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	req_t        req       = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	rsp_t        rsp;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = REG_HIGH_ADDR;
	logic [31:0] cfg_data  = '0;

	three_class_lottery_queue dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// predictor state
	logic [15:0] slot_mem [3][DEPTH];
	int unsigned head_idx [3];
	int unsigned tail_idx [3];
	int unsigned held [3];
	logic [47:0] lcg_x;
	logic [31:0] addr_hi_cfg;
	logic [31:0] addr_mid_cfg;
	logic [15:0] tk_hi_cfg;
	logic [15:0] tk_mid_cfg;
	logic [15:0] tk_total_cfg;

	req_t req_backlog [$];
	rsp_t pending_rsp [$];
	int   mismatches  = 0;
	int   gap_left    = 0;
	int   stall_left  = 0;
	int   hold_left   = 0;
	int   rsp_beats   = 0;
	int   quiet_cycles = 0;
	logic calm_tail   = 1'b0;

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic bit share_covers(logic [47:0] x, logic [16:0] share);
		logic [63:0] lhs;
		logic [63:0] rhs;
		if (share >= {1'b0, tk_total_cfg})
			return 1'b1;
		lhs = {16'd0, x} * {48'd0, tk_total_cfg};
		rhs = {share[15:0], 48'd0};
		return lhs <= rhs;
	endfunction

	function automatic rsp_t lottery_outcome(req_t r);
		rsp_t        o;
		logic [1:0]  cls;
		logic [16:0] both;
		o = '0;
		o.status = ST_DONE;
		cls = CLS_HIGH;
		if (r.opcode == OP_ENQ) begin
			if (r.client_addr == addr_hi_cfg)
				cls = CLS_HIGH;
			else if (r.client_addr == addr_mid_cfg)
				cls = CLS_MID;
			else
				cls = CLS_LOW;
			if (held[cls] >= DEPTH) begin
				o.status = ST_FULL;
			end else begin
				slot_mem[cls][tail_idx[cls]] = r.item_tag;
				tail_idx[cls] = (tail_idx[cls] + 1) % DEPTH;
				held[cls]++;
			end
		end else if (held[0] + held[1] + held[2] == 0) begin
			o.status = ST_EMPTY;
		end else begin
			o.status = ST_LIMIT;
			both = {1'b0, tk_hi_cfg} + {1'b0, tk_mid_cfg};
			for (int n = 0; n < DRAWS; n++) begin
				lcg_x = 48'(lcg_x * LCG_MUL + LCG_ADD);
				if (share_covers(lcg_x, {1'b0, tk_hi_cfg}))
					cls = CLS_HIGH;
				else if (share_covers(lcg_x, both))
					cls = CLS_MID;
				else
					cls = CLS_LOW;
				if (held[cls] != 0) begin
					o.out_tag = slot_mem[cls][head_idx[cls]];
					head_idx[cls] = (head_idx[cls] + 1) % DEPTH;
					held[cls]--;
					o.status = ST_DONE;
					break;
				end
			end
		end
		o.out_class = cls;
		o.total_count = 8'(held[0] + held[1] + held[2]);
		return o;
	endfunction

	function automatic req_t mk_req(logic op, logic [15:0] tag, logic [31:0] addr);
		req_t r;
		r.opcode = op;
		r.item_tag = tag;
		r.client_addr = addr;
		return r;
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin : drive_req
		logic offer;
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
			gap_left = 0;
		end else begin
			offer = req_valid;
			if (req_valid && !req_stall) begin
				pending_rsp.push_back(lottery_outcome(req));
				offer = 1'b0;
			end
			if (!offer) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (req_backlog.size() != 0) begin
					if (!calm_tail && $urandom_range(0, 9) == 0) begin
						gap_left = $urandom_range(1, 18) - 1;
					end else begin
						req <= req_backlog.pop_front();
						offer = 1'b1;
					end
				end
			end
			req_valid <= offer;
		end
	end

	task automatic flag_field(string what, logic [31:0] want, logic [31:0] seen);
		if (seen !== want) begin
			$display("%0t: %s expected %0d got %0d", $time, what, want, seen);
			mismatches++;
		end
	endtask

	// response monitor and receiver stalls
	always @(posedge clk or negedge arst_n) begin : watch_rsp
		logic hold_next;
		rsp_t want;
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			stall_left = 0;
			hold_left = 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				rsp_beats++;
				if (pending_rsp.size() == 0) begin
					$display("%0t: unexpected beat, expected none got status %0d tag %0d",
						$time, rsp.status, rsp.out_tag);
					mismatches++;
				end else begin
					want = pending_rsp.pop_front();
					flag_field("status", 32'(want.status), 32'(rsp.status));
					flag_field("out_tag", 32'(want.out_tag), 32'(rsp.out_tag));
					flag_field("out_class", 32'(want.out_class), 32'(rsp.out_class));
					flag_field("total_count", 32'(want.total_count),
						32'(rsp.total_count));
				end
				if (rsp_beats == 60 || rsp_beats == 500)
					hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				hold_next = 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				hold_next = 1'b1;
			end else if (!calm_tail && $urandom_range(0, 11) == 0) begin
				stall_left = $urandom_range(1, 18) - 1;
				hold_next = 1'b1;
			end else begin
				hold_next = 1'b0;
			end
			rsp_stall <= hold_next;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
					(cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("three_class_lottery_queue_test NOT OK");
				$finish;
			end
		end
	end

	task automatic cfg_write(logic [2:0] idx, logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_HIGH_ADDR: addr_hi_cfg = value;
			REG_MID_ADDR:  addr_mid_cfg = value;
			REG_TK_HIGH:   tk_hi_cfg = value[15:0];
			REG_TK_MID:    tk_mid_cfg = value[15:0];
			REG_TK_TOTAL:  tk_total_cfg = value[15:0];
			REG_SEED:      lcg_x = {value, LCG_SEED_LOW};
			default: ;
		endcase
	endtask

	task automatic settle();
		while (req_backlog.size() != 0 || req_valid || pending_rsp.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic scramble_config();
		int unsigned total;
		int unsigned th;
		total = $urandom_range(1, 65535);
		th = $urandom_range(0, total);
		cfg_write(REG_HIGH_ADDR, $urandom);
		cfg_write(REG_MID_ADDR, $urandom);
		cfg_write(REG_TK_HIGH, th);
		cfg_write(REG_TK_MID, $urandom_range(0, total - th));
		cfg_write(REG_TK_TOTAL, total);
		cfg_write(REG_SEED, $urandom);
		cfg_valid <= 1'b0;
	endtask

	task automatic add_random(int count, int enq_pct);
		req_t r;
		for (int i = 0; i < count; i++) begin
			r.opcode = ($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ;
			r.item_tag = 16'($urandom);
			case ($urandom_range(0, 9))
				0, 1, 2: r.client_addr = addr_hi_cfg;
				3, 4, 5: r.client_addr = addr_mid_cfg;
				6:       r.client_addr = addr_hi_cfg ^ (32'd1 << $urandom_range(0, 31));
				7:       r.client_addr = {32{1'($urandom_range(0, 1))}};
				default: r.client_addr = $urandom;
			endcase
			req_backlog.push_back(r);
		end
	endtask

	initial begin
		for (int c = 0; c < 3; c++) begin
			head_idx[c] = 0;
			tail_idx[c] = 0;
			held[c] = 0;
		end
		lcg_x = LCG_RESET;
		addr_hi_cfg = HIGH_ADDR_RESET;
		addr_mid_cfg = MID_ADDR_RESET;
		tk_hi_cfg = TK_HIGH_RESET;
		tk_mid_cfg = TK_MID_RESET;
		tk_total_cfg = TK_TOTAL_RESET;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (4) @(posedge clk);

		// reset values: empty dequeue, one item each for high and middle, two for low, drain, empty again
		req_backlog.push_back(mk_req(OP_DEQ, 16'h0000, 32'h0000_0000));
		req_backlog.push_back(mk_req(OP_ENQ, 16'hFFFF, HIGH_ADDR_RESET));
		req_backlog.push_back(mk_req(OP_ENQ, 16'h0000, MID_ADDR_RESET));
		req_backlog.push_back(mk_req(OP_ENQ, 16'h1234, 32'h0000_0000));
		req_backlog.push_back(mk_req(OP_ENQ, 16'hA5A5, 32'hFFFF_FFFF));
		repeat (4) req_backlog.push_back(mk_req(OP_DEQ, 16'hFFFF, 32'hFFFF_FFFF));
		req_backlog.push_back(mk_req(OP_DEQ, 16'h0000, HIGH_ADDR_RESET));
		settle();

		// equal addresses, high share covers the total, draw limit
		cfg_write(REG_HIGH_ADDR, 32'h1234_5678);
		cfg_write(REG_MID_ADDR, 32'h1234_5678);
		cfg_write(REG_TK_HIGH, 32'd65535);
		cfg_write(REG_TK_MID, 32'd0);
		cfg_write(REG_TK_TOTAL, 32'd1);
		cfg_write(REG_SEED, 32'hFFFF_FFFF);
		cfg_valid <= 1'b0;
		req_backlog.push_back(mk_req(OP_ENQ, 16'h0001, 32'h1234_5678));
		req_backlog.push_back(mk_req(OP_ENQ, 16'h0002, 32'h0000_0000));
		req_backlog.push_back(mk_req(OP_DEQ, 16'h0000, 32'h0000_0000));
		req_backlog.push_back(mk_req(OP_DEQ, 16'h0000, 32'h0000_0000));
		settle();

		// zero total: every draw lands on high
		cfg_write(REG_TK_TOTAL, 32'd0);
		cfg_write(REG_TK_HIGH, 32'd0);
		cfg_valid <= 1'b0;
		req_backlog.push_back(mk_req(OP_ENQ, 16'h8000, 32'h1234_5678));
		req_backlog.push_back(mk_req(OP_DEQ, 16'h0000, 32'h0000_0000));
		req_backlog.push_back(mk_req(OP_DEQ, 16'h0000, 32'h0000_0000));
		settle();

		// fill past full
		scramble_config();
		add_random(200, 92);
		settle();

		// drain to empty
		scramble_config();
		add_random(250, 20);
		settle();

		// extreme registers: nearly every draw goes low
		cfg_write(REG_HIGH_ADDR, 32'h0000_0000);
		cfg_write(REG_MID_ADDR, 32'hFFFF_FFFF);
		cfg_write(REG_TK_HIGH, 32'd0);
		cfg_write(REG_TK_MID, 32'd0);
		cfg_write(REG_TK_TOTAL, 32'd65535);
		cfg_write(REG_SEED, 32'd0);
		cfg_valid <= 1'b0;
		add_random(100, 50);
		settle();

		scramble_config();
		calm_tail = 1'b1;
		add_random(100, 55);
		settle();

		repeat (20) @(posedge clk);
		if (mismatches == 0 && pending_rsp.size() == 0)
			$display("three_class_lottery_queue_test OK");
		else
			$display("three_class_lottery_queue_test NOT OK");
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/tlq_pkg.sv
hw/rtl/tlq_fifo.sv
hw/rtl/tlq_mac.sv
hw/rtl/three_class_lottery_queue.sv
tb/three_class_lottery_queue_test.sv
